### rtl/cbs_pkg.sv
// Shared widths and types for the cubic Bezier split pipeline.
// Used by cbs_lerp, cubic_bezier_split, cbs_checker and tb_top; no dependencies.
package cbs_pkg;

  localparam int COORD_BITS  = 24;
  localparam int T_FRAC_BITS = 16;

  // Interpolated points stay between their operands, so one extra bit holds them.
  localparam int PT_W   = COORD_BITS + 1;
  localparam int DIFF_W = PT_W + 1;
  localparam int TAN_W  = COORD_BITS + 2;
  localparam int T_W    = T_FRAC_BITS + 1;
  localparam int PROD_W = DIFF_W + T_W + 1;

  // Stream widths, padded up to whole bytes.
  localparam int IN_DATA_W  = ((8 * COORD_BITS + T_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((2 * PT_W + 4 * TAN_W + 7) / 8) * 8;

  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC_BITS;
  localparam int ROUND_HALF = 1 << (T_FRAC_BITS - 1);

  // Load enables for the two register stages inside one interpolator.
  typedef struct packed {
    logic mul;
    logic add;
  } lerp_en_t;

endpackage

### rtl/cbs_lerp.sv
// Two-stage fixed-point interpolator: y = a + round((b - a) * t).
// Depends on cbs_pkg.
module cbs_lerp
  import cbs_pkg::*;
(
  input  logic                   clk,
  input  lerp_en_t               en,
  input  logic signed [PT_W-1:0] a,
  input  logic signed [PT_W-1:0] b,
  input  logic        [T_W-1:0]  t,
  output logic signed [PT_W-1:0] y
);

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_next;
  logic signed [PROD_W-1:0] prod;
  logic signed [PT_W-1:0]   a_d;
  logic signed [PROD_W-1:0] rnd;
  logic signed [PROD_W-1:0] shifted;
  logic signed [DIFF_W-1:0] y_sum;

  assign diff      = $signed({b[PT_W-1], b}) - $signed({a[PT_W-1], a});
  assign prod_next = diff * $signed({1'b0, t});

  // Round to nearest, ties up: add half an lsb, then floor.
  assign rnd     = prod + PROD_W'(ROUND_HALF);
  assign shifted = rnd >>> T_FRAC_BITS;
  assign y_sum   = $signed({a_d[PT_W-1], a_d}) + $signed(shifted[DIFF_W-1:0]);

  always_ff @(posedge clk) begin
    if (en.mul) begin
      prod <= prod_next;
      a_d  <= a;
    end
    if (en.add) begin
      y <= $signed(y_sum[PT_W-1:0]);
    end
  end

endmodule

### rtl/cubic_bezier_split.sv
// Cubic Bezier split by de Casteljau subdivision, signed fixed point.
// 8 register stages; throughput one item per cycle while the output is not stalled.
// Stages: control points, then multiply and round-add for each of three levels,
// then the tangent subtraction into the output register.
// Reset clears the stage valid bits only; payload registers are not reset.
module cubic_bezier_split
  import cbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // start_x, start_y, start_out_dx, start_out_dy, end_x, end_y,
  // end_in_dx, end_in_dy, split_t, zero fill
  input  logic [IN_DATA_W-1:0]   s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // split_x, split_y, left_in_dx, left_in_dy, right_out_dx, right_out_dy, zero fill
  output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

  localparam int NSTAGE     = 8;

  logic [NSTAGE:1] v;
  logic [NSTAGE:1] en;
  logic [T_W-1:0]  t_s [1:5];
  logic [T_W-1:0]  t_in;
  logic [T_W-1:0]  t_clamp;

  logic signed [COORD_BITS-1:0] st [2];
  logic signed [COORD_BITS-1:0] sd [2];
  logic signed [COORD_BITS-1:0] nd [2];
  logic signed [COORD_BITS-1:0] nt [2];

  logic signed [PT_W-1:0] p0 [2];
  logic signed [PT_W-1:0] p1 [2];
  logic signed [PT_W-1:0] p2 [2];
  logic signed [PT_W-1:0] p3 [2];
  logic signed [PT_W-1:0] q0 [2];
  logic signed [PT_W-1:0] q1 [2];
  logic signed [PT_W-1:0] q2 [2];
  logic signed [PT_W-1:0] r0 [2];
  logic signed [PT_W-1:0] r1 [2];
  logic signed [PT_W-1:0] r0_6 [2];
  logic signed [PT_W-1:0] r1_6 [2];
  logic signed [PT_W-1:0] r0_7 [2];
  logic signed [PT_W-1:0] r1_7 [2];
  logic signed [PT_W-1:0] s   [2];

  logic signed [PT_W-1:0]  out_s  [2];
  logic signed [TAN_W-1:0] out_l  [2];
  logic signed [TAN_W-1:0] out_r  [2];

  assign t_in    = s_axis_tdata[8*COORD_BITS +: T_W];
  assign t_clamp = (t_in > T_ONE) ? T_ONE : t_in;

  // Each stage takes a new item when empty or when the next stage moves.
  always_comb begin
    en[NSTAGE] = !v[NSTAGE] || m_axis_tready;
    for (int i = NSTAGE - 1; i >= 1; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  assign s_axis_tready = en[1];
  assign m_axis_tvalid = v[NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= s_axis_tvalid;
      for (int i = 2; i <= NSTAGE; i++) begin
        if (en[i]) v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) t_s[1] <= t_clamp;
    for (int i = 2; i <= 5; i++) begin
      if (en[i]) t_s[i] <= t_s[i-1];
    end
  end

  for (genvar k = 0; k < 2; k++) begin : g_axis
    assign st[k] = $signed(s_axis_tdata[(0 + k) * COORD_BITS +: COORD_BITS]);
    assign sd[k] = $signed(s_axis_tdata[(2 + k) * COORD_BITS +: COORD_BITS]);
    assign nd[k] = $signed(s_axis_tdata[(6 + k) * COORD_BITS +: COORD_BITS]);
    assign nt[k] = $signed(s_axis_tdata[(4 + k) * COORD_BITS +: COORD_BITS]);

    always_ff @(posedge clk) begin
      if (en[1]) begin
        p0[k] <= PT_W'(st[k]);
        p1[k] <= PT_W'(st[k]) + PT_W'(sd[k]);
        p2[k] <= PT_W'(nt[k]) + PT_W'(nd[k]);
        p3[k] <= PT_W'(nt[k]);
      end
    end

    cbs_lerp u_q0 (.clk(clk), .en({en[2], en[3]}),
                   .a(p0[k]), .b(p1[k]), .t(t_s[1]), .y(q0[k]));
    cbs_lerp u_q1 (.clk(clk), .en({en[2], en[3]}),
                   .a(p1[k]), .b(p2[k]), .t(t_s[1]), .y(q1[k]));
    cbs_lerp u_q2 (.clk(clk), .en({en[2], en[3]}),
                   .a(p2[k]), .b(p3[k]), .t(t_s[1]), .y(q2[k]));

    cbs_lerp u_r0 (.clk(clk), .en({en[4], en[5]}),
                   .a(q0[k]), .b(q1[k]), .t(t_s[3]), .y(r0[k]));
    cbs_lerp u_r1 (.clk(clk), .en({en[4], en[5]}),
                   .a(q1[k]), .b(q2[k]), .t(t_s[3]), .y(r1[k]));

    cbs_lerp u_s  (.clk(clk), .en({en[6], en[7]}),
                   .a(r0[k]), .b(r1[k]), .t(t_s[5]), .y(s[k]));

    // Hold r0 and r1 alongside the final interpolation.
    always_ff @(posedge clk) begin
      if (en[6]) begin
        r0_6[k] <= r0[k];
        r1_6[k] <= r1[k];
      end
      if (en[7]) begin
        r0_7[k] <= r0_6[k];
        r1_7[k] <= r1_6[k];
      end
      if (en[8]) begin
        out_s[k] <= s[k];
        out_l[k] <= TAN_W'(r0_7[k]) - TAN_W'(s[k]);
        out_r[k] <= TAN_W'(r1_7[k]) - TAN_W'(s[k]);
      end
    end
  end

  assign m_axis_tdata = OUT_DATA_W'({out_r[1], out_r[0], out_l[1], out_l[0],
                                     out_s[1], out_s[0]});

endmodule

### rtl/cbs_checker.sv
// Port-level checks for cubic_bezier_split, bound to every instance.
// Depends on cbs_pkg and the top-level port list.
module cbs_checker
  import cbs_pkg::*;
(
  input logic                         clk,
  input logic                         rst,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [OUT_DATA_W-1:0]        m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output transfer dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output stage");

endmodule

bind cubic_bezier_split cbs_checker u_cbs_checker (
  .clk          (clk),
  .rst          (rst),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

### bench/tb_top.sv
// Self-checking bench for cubic_bezier_split: random and corner-case curve segments,
// each result compared field by field against a de Casteljau split computed here.
// Depends on cbs_pkg and the cubic_bezier_split RTL.
module tb_top
  import cbs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEG_BITS = 8 * COORD_BITS + T_W;
  localparam int SEG_W = (SEG_BITS + 7) / 8 * 8;
  localparam int RES_BITS = 2 * PT_W + 4 * TAN_W;
  localparam int RES_W = (RES_BITS + 7) / 8 * 8;
  localparam int RANDOM_SEGMENTS = 1930;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  // Fields from the top bit down, so the lowest field lands in bit 0.
  typedef struct packed {
    logic [SEG_W-SEG_BITS-1:0]    pad;
    logic [T_W-1:0]               split_t;
    logic signed [COORD_BITS-1:0] end_in_dy;
    logic signed [COORD_BITS-1:0] end_in_dx;
    logic signed [COORD_BITS-1:0] end_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] start_out_dy;
    logic signed [COORD_BITS-1:0] start_out_dx;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] start_x;
  } segment_t;

  typedef struct packed {
    logic [RES_W-RES_BITS-1:0] pad;
    logic signed [TAN_W-1:0]   right_out_dy;
    logic signed [TAN_W-1:0]   right_out_dx;
    logic signed [TAN_W-1:0]   left_in_dy;
    logic signed [TAN_W-1:0]   left_in_dx;
    logic signed [PT_W-1:0]    split_y;
    logic signed [PT_W-1:0]    split_x;
  } halves_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [SEG_W-1:0] s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [RES_W-1:0] m_axis_tdata;

  segment_t segments_to_send[$];
  halves_t  split_queue[$];
  int       n_sent = 0;
  int       n_total = 0;
  int       n_errors = 0;
  int       n_cycles = 0;
  bit       seg_taken = 1'b0;

  cubic_bezier_split dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- prediction

  // a + round((b - a) * t), ties toward plus infinity
  function automatic longint mix_point(longint a, longint b, longint t);
    return a + (((b - a) * t + longint'(ROUND_HALF)) >>> T_FRAC_BITS);
  endfunction

  function automatic void split_axis(input longint a0, input longint d0, input longint a3,
                                     input longint d3, input longint t, output longint s,
                                     output longint left_tan, output longint right_tan);
    longint a1, a2, q0, q1, q2, r0, r1;
    a1 = a0 + d0;
    a2 = a3 + d3;
    q0 = mix_point(a0, a1, t);
    q1 = mix_point(a1, a2, t);
    q2 = mix_point(a2, a3, t);
    r0 = mix_point(q0, q1, t);
    r1 = mix_point(q1, q2, t);
    s = mix_point(r0, r1, t);
    left_tan = r0 - s;
    right_tan = r1 - s;
  endfunction

  function automatic halves_t split_curve(segment_t seg);
    halves_t h;
    longint  t, s, lt, rt;
    t = longint'(seg.split_t);
    if (seg.split_t > T_ONE) t = longint'(T_ONE);  // never extrapolate
    h = '0;
    split_axis(seg.start_x, seg.start_out_dx, seg.end_x, seg.end_in_dx, t, s, lt, rt);
    h.split_x = s[PT_W-1:0];
    h.left_in_dx = lt[TAN_W-1:0];
    h.right_out_dx = rt[TAN_W-1:0];
    split_axis(seg.start_y, seg.start_out_dy, seg.end_y, seg.end_in_dy, t, s, lt, rt);
    h.split_y = s[PT_W-1:0];
    h.left_in_dy = lt[TAN_W-1:0];
    h.right_out_dy = rt[TAN_W-1:0];
    return h;
  endfunction

  // ---------------------------------------------------------------- stimulus

  task automatic add_segment(logic signed [COORD_BITS-1:0] sx, logic signed [COORD_BITS-1:0] sy,
                             logic signed [COORD_BITS-1:0] sdx,
                             logic signed [COORD_BITS-1:0] sdy,
                             logic signed [COORD_BITS-1:0] ex, logic signed [COORD_BITS-1:0] ey,
                             logic signed [COORD_BITS-1:0] edx,
                             logic signed [COORD_BITS-1:0] edy, logic [T_W-1:0] t);
    segment_t seg;
    seg = '0;
    seg.start_x = sx;
    seg.start_y = sy;
    seg.start_out_dx = sdx;
    seg.start_out_dy = sdy;
    seg.end_x = ex;
    seg.end_y = ey;
    seg.end_in_dx = edx;
    seg.end_in_dy = edy;
    seg.split_t = t;
    segments_to_send.insert(segments_to_send.size(), seg);
  endtask

  function automatic logic signed [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return C_MAX;
          1: return C_MIN;
          2: return '0;
          3: return '1;
          default: return COORD_BITS'(1);
        endcase
      end
      1, 2: return COORD_BITS'(int'($urandom_range(511)) - 256);
      default: return COORD_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [T_W-1:0] pick_t();
    case ($urandom_range(9))
      7: return T_W'($urandom_range(32'(T_ONE) + 1, (1 << T_W) - 1));
      8: begin
        case ($urandom_range(5))
          0: return '0;
          1: return T_W'(1);
          2: return T_ONE >> 1;
          3: return T_ONE - T_W'(1);
          4: return T_ONE;
          default: return '1;
        endcase
      end
      9: return T_W'($urandom_range(16));
      default: return T_W'($urandom_range(32'(T_ONE)));
    endcase
  endfunction

  task automatic add_random_segment(logic [T_W-1:0] t);
    add_segment(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                pick_coord(), pick_coord(), pick_coord(), pick_coord(), t);
  endtask

  // ---------------------------------------------------------------- driver / monitor

  // Split the run into thirds: sender idles lightly, then heavily, then never.
  function automatic int sender_idle_pct();
    if (n_sent < n_total / 3) return 23;
    if (n_sent < 2 * n_total / 3) return 61;
    return 0;
  endfunction

  function automatic int receiver_idle_pct();
    if (n_sent < n_total / 3) return 61;
    if (n_sent < 2 * n_total / 3) return 23;
    return 0;
  endfunction

  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || seg_taken)) begin
      if (segments_to_send.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= segments_to_send.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst) m_axis_tready <= ($urandom_range(99) >= receiver_idle_pct());
  end

  task automatic note_mismatch(string field, longint want, longint got);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    n_errors++;
  endtask

  always @(posedge clk) begin
    halves_t got, want;
    n_cycles++;
    seg_taken = s_axis_tvalid && s_axis_tready && !rst;
    if (seg_taken) begin
      split_queue.insert(split_queue.size(), split_curve(segment_t'(s_axis_tdata)));
      n_sent++;
    end
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = halves_t'(m_axis_tdata);
      if (split_queue.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, m_axis_tdata);
        n_errors++;
      end else begin
        want = split_queue.pop_front();
        if (got.split_x !== want.split_x) note_mismatch("split_x", want.split_x, got.split_x);
        if (got.split_y !== want.split_y) note_mismatch("split_y", want.split_y, got.split_y);
        if (got.left_in_dx !== want.left_in_dx)
          note_mismatch("left_in_dx", want.left_in_dx, got.left_in_dx);
        if (got.left_in_dy !== want.left_in_dy)
          note_mismatch("left_in_dy", want.left_in_dy, got.left_in_dy);
        if (got.right_out_dx !== want.right_out_dx)
          note_mismatch("right_out_dx", want.right_out_dx, got.right_out_dx);
        if (got.right_out_dy !== want.right_out_dy)
          note_mismatch("right_out_dy", want.right_out_dy, got.right_out_dy);
        if (got.pad !== '0) note_mismatch("zero fill", 0, longint'(got.pad));
      end
    end
  end

  always @(posedge clk) begin
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, split_queue.size());
      $display("FAIL cubic_bezier_split");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // Corner cases: field extremes, t at zero, one lsb, half, just below one, one and above one.
    add_segment('0, '0, '0, '0, '0, '0, '0, '0, '0);
    add_segment(C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, C_MAX, T_ONE);
    add_segment(C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, C_MIN, '0);
    add_segment(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, T_ONE >> 1);
    add_segment(C_MIN, C_MAX, C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, T_ONE - T_W'(1));
    add_segment(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, T_W'(1));
    add_segment(C_MIN, C_MAX, C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, T_ONE >> 1);
    add_segment(C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, T_ONE + T_W'(1));
    add_segment(C_MAX, C_MIN, C_MAX, C_MIN, C_MIN, C_MAX, C_MIN, C_MAX, '1);
    // Rounding ties in both directions.
    add_segment('0, '0, COORD_BITS'(1), COORD_BITS'(-1), COORD_BITS'(1), COORD_BITS'(-1),
                '0, '0, T_ONE >> 1);
    add_segment('0, '0, COORD_BITS'(-1), COORD_BITS'(1), COORD_BITS'(-1), COORD_BITS'(1),
                COORD_BITS'(3), COORD_BITS'(-3), T_ONE >> 1);
    add_segment(COORD_BITS'(5), COORD_BITS'(-5), COORD_BITS'(3), COORD_BITS'(-3),
                COORD_BITS'(-7), COORD_BITS'(7), COORD_BITS'(1), COORD_BITS'(-1), T_ONE >> 2);
    add_random_segment('0);
    add_random_segment('0);
    add_random_segment(T_ONE);
    add_random_segment(T_ONE);
    add_random_segment(T_ONE + T_W'(1));
    add_random_segment('1);
    add_random_segment(T_W'(1));
    add_random_segment(T_ONE - T_W'(1));
    repeat (RANDOM_SEGMENTS) add_random_segment(pick_t());
    n_total = segments_to_send.size();

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (segments_to_send.size() != 0 || s_axis_tvalid || split_queue.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (n_errors == 0 && split_queue.size() == 0) begin
      $display("PASS cubic_bezier_split");
    end else begin
      $display("FAIL cubic_bezier_split");
    end
    $finish;
  end

endmodule
